// ----- rtl/dfs_path_search_unit_defines.svh -----
// Assertion macros shared by the RTL files of the path search unit.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef DFS_PATH_SEARCH_UNIT_DEFINES_SVH
`define DFS_PATH_SEARCH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dfs_pkg.sv -----
package dfs_pkg;

	localparam int NODE_W = 4;
	localparam int ACT_W  = 2;

	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_START,
		ST_FETCH,
		ST_CHECK,
		ST_POP,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMIT_GOAL,
		ST_MISS
	} dfs_state_t;

	typedef enum logic [2:0] {
		OUT_STORED,
		OUT_DROPPED,
		OUT_MISS,
		OUT_PATH,
		OUT_GOAL
	} dfs_out_kind_t;

	typedef struct packed {
		logic          load_in;
		logic          clr_deg;
		logic          sel_from;
		logic          add_wr;
		logic          srch_init;
		logic          nbr_rd;
		logic          push;
		logic          pop;
		logic          pop_load;
		logic          emit_rd;
		logic          out_ld;
		dfs_out_kind_t out_kind;
	} dfs_cmd_t;

	typedef struct packed {
		logic edge_ok;
		logic ends_ok;
		logic start_is_goal;
		logic has_nbr;
		logic depth_one;
		logic push_ok;
		logic v_is_goal;
		logic emit_tail;
		logic out_free;
	} dfs_sts_t;

endpackage

// ----- rtl/dfs_path_search_unit.sv -----
// Channel  Handshake               Payload
// input    in_valid / in_ready     action, from_node, to_node, start_node, goal_node
// output   out_valid / out_ready   node, found, status, last
//
// An edge add passes through the add state and a clear is done in idle; a search
// walks each edge through the fetch and check states and each backtrack through
// the fetch and pop states, then sends each path word through a read and an output state.
// The walk is bound by the single read port of the neighbor memory.
// Reset is asynchronous and empties every neighbor list; no clearing pass is run.
// A word waiting in the output register stalls only the next output load.
module dfs_path_search_unit
	import dfs_pkg::*;
#(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  logic [NODE_W-1:0] start_node,
	input  logic [NODE_W-1:0] goal_node,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] node,
	output logic              found,
	output logic              status,
	output logic              last
);

	dfs_cmd_t cmd;
	dfs_sts_t sts;

	dfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	dfs_dp #(
		.NODES      (NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.from_node  (from_node),
		.to_node    (to_node),
		.start_node (start_node),
		.goal_node  (goal_node),
		.out_ready  (out_ready),
		.sts        (sts),
		.out_valid  (out_valid),
		.node       (node),
		.found      (found),
		.status     (status),
		.last       (last)
	);

endmodule

// ----- rtl/dfs_ctrl.sv -----
`include "dfs_path_search_unit_defines.svh"

module dfs_ctrl
	import dfs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [ACT_W-1:0] action,
	input  dfs_sts_t         sts,
	output logic             in_ready,
	output dfs_cmd_t         cmd
);

	dfs_state_t state_q;
	dfs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.out_kind = OUT_STORED;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					unique case (action)
						ACT_ADD:    state_d = ST_ADD;
						ACT_SEARCH: state_d = ST_START;
						ACT_CLEAR:  cmd.clr_deg = 1'b1;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				cmd.sel_from = 1'b1;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (sts.edge_ok) begin
						cmd.add_wr   = 1'b1;
						cmd.out_kind = OUT_STORED;
					end else begin
						cmd.out_kind = OUT_DROPPED;
					end
					state_d = ST_IDLE;
				end
			end
			ST_START: begin
				cmd.srch_init = 1'b1;
				priority if (!sts.ends_ok) begin
					state_d = ST_MISS;
				end else if (sts.start_is_goal) begin
					state_d = ST_EMIT_GOAL;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				priority if (sts.has_nbr) begin
					cmd.nbr_rd = 1'b1;
					state_d    = ST_CHECK;
				end else if (sts.depth_one) begin
					state_d = ST_MISS;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_POP;
				end
			end
			ST_CHECK: begin
				if (sts.push_ok) begin
					cmd.push = 1'b1;
					state_d  = sts.v_is_goal ? ST_EMIT_RD : ST_FETCH;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_POP: begin
				cmd.pop_load = 1'b1;
				state_d      = ST_FETCH;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_PATH;
					state_d      = sts.emit_tail ? ST_EMIT_GOAL : ST_EMIT_RD;
				end
			end
			ST_EMIT_GOAL: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_GOAL;
					state_d      = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = OUT_MISS;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`DFS_ASSERT_NOW(a_out_ld_free, cmd.out_ld, sts.out_free, "word loaded into a full output register")
	`DFS_ASSERT_NEXT(a_push_next, cmd.push, state_q == ST_FETCH || state_q == ST_EMIT_RD, "bad state after push")
	`DFS_ASSERT_NOW(a_ready_idle, in_ready, state_q == ST_IDLE, "word accepted outside idle")

endmodule

// ----- rtl/dfs_dp.sv -----
`include "dfs_path_search_unit_defines.svh"

module dfs_dp
	import dfs_pkg::*;
#(
	parameter int NODES      = 16,
	parameter int MAX_DEGREE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dfs_cmd_t          cmd,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  logic [NODE_W-1:0] start_node,
	input  logic [NODE_W-1:0] goal_node,
	input  logic              out_ready,
	output dfs_sts_t          sts,
	output logic              out_valid,
	output logic [NODE_W-1:0] node,
	output logic              found,
	output logic              status,
	output logic              last
);

	localparam int NW    = $clog2(NODES);
	localparam int DPW   = $clog2(NODES + 1);
	localparam int IW    = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH = NODES * MAX_DEGREE;
	localparam int AW    = $clog2(DEPTH);

	logic [NODE_W-1:0] from_q, to_q, start_q, goal_q;

	logic [IW-1:0]     deg_q [NODES];
	logic [NODE_W-1:0] nbr_mem [DEPTH];
	logic [NODE_W-1:0] path_mem [NODES];
	logic [IW-1:0]     iter_mem [NODES];

	logic [NODE_W-1:0] nbr_rd_q;
	logic [NODE_W-1:0] path_rd_q;
	logic [IW-1:0]     iter_rd_q;

	logic [NODES-1:0]  visited_q;
	logic [NODE_W-1:0] cur_node_q;
	logic [IW-1:0]     cur_it_q;
	logic [DPW-1:0]    depth_q;
	logic [NW-1:0]     emit_idx_q;

	logic              out_valid_q;
	logic [NODE_W-1:0] node_q;
	logic              found_q, status_q, last_q;

	logic [NW-1:0] from_idx, cur_idx, start_idx, v_idx, deg_idx;
	logic [NW-1:0] top_wr, top_rd, stk_rd_addr;
	logic [IW-1:0] deg_rd;
	logic [AW-1:0] nbr_wr_addr, nbr_rd_addr;
	logic          v_ok;

	assign from_idx  = NW'(from_q);
	assign cur_idx   = NW'(cur_node_q);
	assign start_idx = NW'(start_q);
	assign v_idx     = NW'(nbr_rd_q);
	assign deg_idx   = cmd.sel_from ? from_idx : cur_idx;
	assign deg_rd    = deg_q[deg_idx];
	assign top_wr    = NW'(depth_q - DPW'(1));
	assign top_rd    = NW'(depth_q - DPW'(2));
	assign stk_rd_addr = cmd.emit_rd ? emit_idx_q : top_rd;

	assign nbr_wr_addr = AW'(32'(from_idx) * MAX_DEGREE + 32'(deg_rd));
	assign nbr_rd_addr = AW'(32'(cur_idx) * MAX_DEGREE + 32'(cur_it_q));

	assign v_ok = 32'(nbr_rd_q) < NODES;

	assign sts.edge_ok       = (32'(from_q) < NODES) && (32'(to_q) < NODES)
				&& (32'(deg_rd) < MAX_DEGREE);
	assign sts.ends_ok       = (32'(start_q) < NODES) && (32'(goal_q) < NODES);
	assign sts.start_is_goal = start_q == goal_q;
	assign sts.has_nbr       = cur_it_q < deg_rd;
	assign sts.depth_one     = depth_q == DPW'(1);
	assign sts.push_ok       = v_ok && !visited_q[v_idx] && (32'(depth_q) < NODES);
	assign sts.v_is_goal     = nbr_rd_q == goal_q;
	assign sts.emit_tail     = 32'(emit_idx_q) + 32'd2 == 32'(depth_q);
	assign sts.out_free      = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			from_q  <= from_node;
			to_q    <= to_node;
			start_q <= start_node;
			goal_q  <= goal_node;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				deg_q[i] <= '0;
			end
		end else if (cmd.clr_deg) begin
			for (int i = 0; i < NODES; i++) begin
				deg_q[i] <= '0;
			end
		end else if (cmd.add_wr) begin
			deg_q[from_idx] <= deg_rd + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			nbr_mem[nbr_wr_addr] <= to_q;
		end
		if (cmd.nbr_rd) begin
			nbr_rd_q <= nbr_mem[nbr_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			path_mem[top_wr] <= cur_node_q;
			iter_mem[top_wr] <= cur_it_q;
		end
		if (cmd.pop || cmd.emit_rd) begin
			path_rd_q <= path_mem[stk_rd_addr];
		end
		if (cmd.pop) begin
			iter_rd_q <= iter_mem[top_rd];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q  <= '0;
			cur_node_q <= '0;
			cur_it_q   <= '0;
			depth_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.srch_init) begin
				visited_q  <= NODES'(1) << start_idx;
				cur_node_q <= start_q;
				cur_it_q   <= '0;
				depth_q    <= DPW'(1);
				emit_idx_q <= '0;
			end
			if (cmd.nbr_rd) begin
				cur_it_q <= cur_it_q + IW'(1);
			end
			if (cmd.push) begin
				visited_q[v_idx] <= 1'b1;
				cur_node_q       <= nbr_rd_q;
				cur_it_q         <= '0;
				depth_q          <= depth_q + DPW'(1);
			end
			if (cmd.pop) begin
				depth_q <= depth_q - DPW'(1);
			end
			if (cmd.pop_load) begin
				cur_node_q <= path_rd_q;
				cur_it_q   <= iter_rd_q;
			end
			if (cmd.out_ld && cmd.out_kind == OUT_PATH) begin
				emit_idx_q <= emit_idx_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			unique case (cmd.out_kind)
				OUT_PATH: node_q <= path_rd_q;
				OUT_GOAL: node_q <= cur_node_q;
				default:  node_q <= '0;
			endcase
			found_q  <= cmd.out_kind == OUT_PATH || cmd.out_kind == OUT_GOAL;
			status_q <= cmd.out_kind == OUT_DROPPED;
			last_q   <= cmd.out_kind != OUT_PATH;
		end
	end

	assign out_valid = out_valid_q;
	assign node      = node_q;
	assign found     = found_q;
	assign status    = status_q;
	assign last      = last_q;

	`DFS_ASSERT_NOW(a_depth_bound, 1'b1, 32'(depth_q) <= NODES, "stack depth above node count")
	`DFS_ASSERT_NOW(a_pop_depth, cmd.pop, depth_q >= DPW'(2), "pop would empty the stack")
	`DFS_ASSERT_NOW(a_emit_range, cmd.emit_rd, 32'(emit_idx_q) + 32'd1 < 32'(depth_q), "path read beyond stack")

endmodule
